// ===== sv/clcd_pkg.sv =====
// Shared types, constants and power-up tables for the character LCD expander feeder.
package clcd_pkg;

  localparam int QUEUE_DEPTH = 64;

  // Request queue between front and back
  localparam int ITEMQ_DEPTH = 2;
  localparam int ITEMQ_AW    = $clog2(ITEMQ_DEPTH);

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_RS_POS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EN_POS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_POS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CMD_MARK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_MARK = 3'd4;

  localparam logic [2:0] RS_POS_RST    = 3'd0;
  localparam logic [2:0] EN_POS_RST    = 3'd2;
  localparam logic [2:0] LIGHT_POS_RST = 3'd3;
  localparam logic [7:0] CMD_MARK_RST  = 8'd1;
  localparam logic [7:0] DATA_MARK_RST = 8'd2;

  localparam logic [7:0] HI_NIB_MASK = 8'b1111_0000;
  localparam logic [7:0] LO_NIB_MASK = 8'b0000_1111;

  // Power-up sequence: step 0 clears the queue, steps 1..9 send frames,
  // step 10 turns the block ready.
  localparam logic [3:0] INIT_STEP_CLEAR = 4'd0;
  localparam logic [3:0] INIT_STEP_DONE  = 4'd10;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2,
    OP_DONE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       err;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_EMIT,
    ST_OVF
  } back_state_t;

  function automatic logic [7:0] init_hi(input logic [3:0] step);
    logic [7:0] v;
    unique case (step)
      4'd1, 4'd2: v = 8'b0011_0000;
      4'd3, 4'd4: v = 8'b0010_0000;
      4'd5:       v = 8'b1000_0000;
      4'd8:       v = 8'b0001_0000;
      default:    v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] init_lo(input logic [3:0] step);
    logic [7:0] v;
    unique case (step)
      4'd6:    v = 8'b1100_0000;
      4'd9:    v = 8'b0110_0000;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic init_four(input logic [3:0] step);
    return (step == 4'd6) || (step == 4'd9);
  endfunction

endpackage

// ===== sv/char_lcd_i2c_expander_feeder.sv =====
// Top level of the character LCD feeder for a 4-bit display behind an I2C port expander.
//
// Requests (push byte, start, service tick, bus done) enter a two-entry request queue and are
// carried out one at a time by the back end. A push, start or bus done that sends nothing takes
// one cycle in the back end; a service tick takes two cycles of queue memory reads (three when
// a command or data marker is skipped) and then holds its frame on the result port, one
// expander byte per pop, so a four-byte frame needs at least six to seven cycles. A bus error
// resends the held frame. The single-read-port byte queue sets the fetch latency. A push to a
// full queue returns one result with overflow set. No clearing pass: queue entries are only
// read after being written. Configuration writes are always ready.
module char_lcd_i2c_expander_feeder #(
  parameter int QUEUE_DEPTH = clcd_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [1:0]                     in_kind,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_bus_error,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [7:0]                     out_expander_byte,
  output logic                           out_last_of_frame,
  output logic                           out_overflow,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [clcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  logic            item_valid;
  logic            item_take;
  clcd_pkg::item_t item;

  assign cfg_ready = 1'b1;

  clcd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_kind      (in_kind),
    .in_data_byte (in_data_byte),
    .in_bus_error (in_bus_error),
    .item_valid   (item_valid),
    .item         (item),
    .item_take    (item_take)
  );

  clcd_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (item_valid),
    .item              (item),
    .item_take         (item_take),
    .cfg_valid         (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_expander_byte (out_expander_byte),
    .out_last_of_frame (out_last_of_frame),
    .out_overflow      (out_overflow)
  );

endmodule

// ===== sv/clcd_front.sv =====
// Front end: takes requests from the input port and queues them, decoded, for the back end.
module clcd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [1:0]           in_kind,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_bus_error,
  output logic                 item_valid,
  output clcd_pkg::item_t      item,
  input  logic                 item_take
);

  localparam int AW = clcd_pkg::ITEMQ_AW;

  clcd_pkg::item_t buf_r [clcd_pkg::ITEMQ_DEPTH];
  logic [AW-1:0]   wp_r, wp_nxt;
  logic [AW-1:0]   rp_r, rp_nxt;
  logic [AW:0]     cnt_r, cnt_nxt;
  logic            wr_en;
  logic            rd_en;
  clcd_pkg::item_t in_item;

  always_comb begin
    in_item.op   = clcd_pkg::op_t'(in_kind);
    in_item.data = in_data_byte;
    in_item.err  = in_bus_error;
  end

  assign in_full    = (cnt_r == (AW+1)'(clcd_pkg::ITEMQ_DEPTH));
  assign item_valid = (cnt_r != '0);
  assign item       = buf_r[rp_r];

  assign wr_en = in_push && !in_full;
  assign rd_en = item_take && item_valid;

  always_comb begin
    wp_nxt  = wr_en ? wp_r + 1'b1 : wp_r;
    rp_nxt  = rd_en ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_r[wp_r] <= in_item;
    end
  end

endmodule

// ===== sv/clcd_back.sv =====
// Back end: byte queue, power-up sequencer, frame builder and result emitter.
module clcd_back #(
  parameter int QUEUE_DEPTH = clcd_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              item_valid,
  input  clcd_pkg::item_t                   item,
  output logic                              item_take,
  input  logic                              cfg_valid,
  input  logic [clcd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [7:0]                        cfg_data,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [7:0]                        out_expander_byte,
  output logic                              out_last_of_frame,
  output logic                              out_overflow
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);

  clcd_pkg::back_state_t state_r, state_nxt;

  logic [7:0]    mem [QUEUE_DEPTH];
  logic [7:0]    rdata_r;
  logic [IW-1:0] rd_addr;
  logic          mem_we;

  logic [IW-1:0] wr_idx_r, wr_idx_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;
  logic          q_empty_r, q_empty_nxt;
  logic          sending_r, sending_nxt;
  logic [3:0]    step_r, step_nxt;
  logic          ready_r, ready_nxt;
  logic          light_on_r, light_on_nxt;
  logic          pending_r, pending_nxt;
  logic [7:0]    frame_r [4];
  logic [7:0]    frame_nxt [4];
  logic          four_r, four_nxt;
  logic [1:0]    idx_r, idx_nxt;
  logic          is_data_r, is_data_nxt;

  logic [2:0]    rs_pos_r, en_pos_r, lt_pos_r;
  logic [7:0]    cmd_mark_r, data_mark_r;

  logic          q_full;
  logic          svc_ok;
  logic [IW-1:0] rd_idx_inc;
  logic          is_cmd, is_mark;
  logic          done_ok;
  logic          init_emit;
  logic          last_byte;
  logic [7:0]    en_mask;
  logic [7:0]    ctl;
  logic          svc_is_data;
  logic [7:0]    init_h, init_l;

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  assign item_take  = (state_r == clcd_pkg::ST_IDLE) && item_valid;
  assign q_full     = !q_empty_r && (wr_idx_r == rd_idx_r);
  assign svc_ok     = sending_r && !pending_r && !q_empty_r;
  assign rd_idx_inc = next_idx(rd_idx_r);
  assign is_cmd     = (rdata_r == cmd_mark_r);
  assign is_mark    = is_cmd || (rdata_r == data_mark_r);
  assign done_ok    = pending_r && !item.err;
  assign init_emit  = (step_r != clcd_pkg::INIT_STEP_CLEAR) &&
                      (step_r < clcd_pkg::INIT_STEP_DONE);
  assign last_byte  = (idx_r == (four_r ? 2'd3 : 2'd1));
  assign mem_we     = item_take && (item.op == clcd_pkg::OP_PUSH) && !q_full;

  // RD0 looks one entry past the marker; the second fetch uses that address
  assign rd_addr    = (state_r == clcd_pkg::ST_RD0) ? rd_idx_inc : rd_idx_r;

  assign en_mask     = 8'd1 << en_pos_r;
  assign svc_is_data = (state_r == clcd_pkg::ST_RD1) ? is_data_r : 1'b1;
  assign ctl         = (svc_is_data ? (8'd1 << rs_pos_r) : 8'd0) |
                       (light_on_r  ? (8'd1 << lt_pos_r) : 8'd0);
  assign init_h      = clcd_pkg::init_hi(step_r);
  assign init_l      = clcd_pkg::init_lo(step_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      clcd_pkg::ST_IDLE: begin
        if (item_valid) begin
          unique case (item.op)
            clcd_pkg::OP_PUSH: state_nxt = q_full ? clcd_pkg::ST_OVF : clcd_pkg::ST_IDLE;
            clcd_pkg::OP_TICK: begin
              if (ready_r) begin
                state_nxt = svc_ok ? clcd_pkg::ST_RD0 : clcd_pkg::ST_IDLE;
              end else begin
                state_nxt = init_emit ? clcd_pkg::ST_EMIT : clcd_pkg::ST_IDLE;
              end
            end
            clcd_pkg::OP_DONE:
              state_nxt = (pending_r && item.err) ? clcd_pkg::ST_EMIT : clcd_pkg::ST_IDLE;
            default: state_nxt = clcd_pkg::ST_IDLE;
          endcase
        end
      end
      clcd_pkg::ST_RD0: begin
        if (!is_mark) begin
          state_nxt = clcd_pkg::ST_EMIT;
        end else if (rd_idx_inc == wr_idx_r) begin
          // marker without its byte yet: wait for a later tick
          state_nxt = clcd_pkg::ST_IDLE;
        end else begin
          state_nxt = clcd_pkg::ST_RD1;
        end
      end
      clcd_pkg::ST_RD1: state_nxt = clcd_pkg::ST_EMIT;
      clcd_pkg::ST_EMIT: begin
        if (out_pop && last_byte) begin
          state_nxt = clcd_pkg::ST_IDLE;
        end
      end
      clcd_pkg::ST_OVF: begin
        if (out_pop) begin
          state_nxt = clcd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = clcd_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    wr_idx_nxt   = wr_idx_r;
    rd_idx_nxt   = rd_idx_r;
    q_empty_nxt  = q_empty_r;
    sending_nxt  = sending_r;
    step_nxt     = step_r;
    ready_nxt    = ready_r;
    light_on_nxt = light_on_r;
    pending_nxt  = pending_r;
    four_nxt     = four_r;
    idx_nxt      = idx_r;
    is_data_nxt  = is_data_r;
    for (int k = 0; k < 4; k++) begin
      frame_nxt[k] = frame_r[k];
    end

    unique case (state_r)
      clcd_pkg::ST_IDLE: begin
        idx_nxt = 2'd0;
        if (item_valid) begin
          unique case (item.op)
            clcd_pkg::OP_PUSH: begin
              if (!q_full) begin
                q_empty_nxt = 1'b0;
                wr_idx_nxt  = next_idx(wr_idx_r);
              end
            end
            clcd_pkg::OP_START: sending_nxt = 1'b1;
            clcd_pkg::OP_TICK: begin
              if (!ready_r) begin
                if (step_r >= clcd_pkg::INIT_STEP_DONE) begin
                  ready_nxt    = 1'b1;
                  light_on_nxt = 1'b1;
                  step_nxt     = clcd_pkg::INIT_STEP_DONE;
                end else if (step_r == clcd_pkg::INIT_STEP_CLEAR) begin
                  q_empty_nxt = 1'b1;
                  rd_idx_nxt  = '0;
                  wr_idx_nxt  = '0;
                  step_nxt    = step_r + 4'd1;
                end else begin
                  frame_nxt[0] = init_h | en_mask;
                  frame_nxt[1] = init_h;
                  frame_nxt[2] = init_l | en_mask;
                  frame_nxt[3] = init_l;
                  four_nxt     = clcd_pkg::init_four(step_r);
                  step_nxt     = step_r + 4'd1;
                end
              end
            end
            clcd_pkg::OP_DONE: begin
              if (pending_r) begin
                four_nxt = 1'b1;
              end
              if (done_ok) begin
                pending_nxt = 1'b0;
                rd_idx_nxt  = rd_idx_inc;
                if (rd_idx_inc == wr_idx_r) begin
                  sending_nxt = 1'b0;
                  q_empty_nxt = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      clcd_pkg::ST_RD0, clcd_pkg::ST_RD1: begin
        if ((state_r == clcd_pkg::ST_RD0) && is_mark) begin
          is_data_nxt = !is_cmd;
          if (rd_idx_inc != wr_idx_r) begin
            rd_idx_nxt = rd_idx_inc;
          end
        end else begin
          frame_nxt[1] = ctl | (rdata_r & clcd_pkg::HI_NIB_MASK);
          frame_nxt[0] = ctl | (rdata_r & clcd_pkg::HI_NIB_MASK) | en_mask;
          frame_nxt[3] = ctl | {rdata_r[3:0], 4'd0};
          frame_nxt[2] = ctl | {rdata_r[3:0], 4'd0} | en_mask;
          four_nxt     = 1'b1;
          pending_nxt  = 1'b1;
        end
      end
      clcd_pkg::ST_EMIT: begin
        if (out_pop) begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign out_empty         = !((state_r == clcd_pkg::ST_EMIT) ||
                               (state_r == clcd_pkg::ST_OVF));
  assign out_overflow      = (state_r == clcd_pkg::ST_OVF);
  assign out_expander_byte = out_overflow ? 8'd0 : frame_r[idx_r];
  assign out_last_of_frame = !out_overflow && last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= clcd_pkg::ST_IDLE;
      wr_idx_r   <= '0;
      rd_idx_r   <= '0;
      q_empty_r  <= 1'b1;
      sending_r  <= 1'b0;
      step_r     <= clcd_pkg::INIT_STEP_CLEAR;
      ready_r    <= 1'b0;
      light_on_r <= 1'b0;
      pending_r  <= 1'b0;
      idx_r      <= 2'd0;
    end else begin
      state_r    <= state_nxt;
      wr_idx_r   <= wr_idx_nxt;
      rd_idx_r   <= rd_idx_nxt;
      q_empty_r  <= q_empty_nxt;
      sending_r  <= sending_nxt;
      step_r     <= step_nxt;
      ready_r    <= ready_nxt;
      light_on_r <= light_on_nxt;
      pending_r  <= pending_nxt;
      idx_r      <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    four_r    <= four_nxt;
    is_data_r <= is_data_nxt;
    for (int k = 0; k < 4; k++) begin
      frame_r[k] <= frame_nxt[k];
    end
  end

  // Byte queue storage
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx_r] <= item.data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_pos_r    <= clcd_pkg::RS_POS_RST;
      en_pos_r    <= clcd_pkg::EN_POS_RST;
      lt_pos_r    <= clcd_pkg::LIGHT_POS_RST;
      cmd_mark_r  <= clcd_pkg::CMD_MARK_RST;
      data_mark_r <= clcd_pkg::DATA_MARK_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        clcd_pkg::CFG_RS_POS:    rs_pos_r    <= cfg_data[2:0];
        clcd_pkg::CFG_EN_POS:    en_pos_r    <= cfg_data[2:0];
        clcd_pkg::CFG_LIGHT_POS: lt_pos_r    <= cfg_data[2:0];
        clcd_pkg::CFG_CMD_MARK:  cmd_mark_r  <= cfg_data;
        clcd_pkg::CFG_DATA_MARK: data_mark_r <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/clcd_checker.sv =====
// Port-level checker for the LCD feeder, bound to the top level.
module clcd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_expander_byte,
  input logic       out_last_of_frame,
  input logic       out_overflow
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result port not empty after reset");

  a_ovf_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_overflow |-> out_expander_byte == 8'd0 && !out_last_of_frame)
    else $error("overflow result carries a byte");

  a_frame_end_gap: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_pop && (out_last_of_frame || out_overflow) |=> out_empty)
    else $error("result follows frame end without a gap");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_expander_byte) &&
      $stable(out_last_of_frame) && $stable(out_overflow))
    else $error("waiting result changed");

endmodule

bind char_lcd_i2c_expander_feeder clcd_checker u_clcd_checker (.*);

// ===== sim/char_lcd_i2c_expander_feeder_tb.sv =====
// Self-checking testbench for the character LCD feeder: random requests, predicted expander bytes.
`timescale 1ns / 1ps

import clcd_pkg::*;

typedef struct packed {
  logic [7:0] xbyte;
  logic       last;
  logic       ovf;
} lcd_out_t;

// Power-up nibbles per step; a nonzero low nibble marks a four-byte frame
localparam logic [0:9][7:0] BOOT_HI = {8'h00, 8'h30, 8'h30, 8'h20, 8'h20,
                                       8'h80, 8'h00, 8'h00, 8'h10, 8'h00};
localparam logic [0:9][7:0] BOOT_LO = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                       8'h00, 8'hC0, 8'h00, 8'h00, 8'h60};

class frame_tracker;
  logic [7:0]  store [QUEUE_DEPTH];
  int unsigned wr, rd, step;
  bit          q_empty, ovf_seen, sending, rdy, light_on, frame_busy;
  logic [7:0]  frame [4];
  logic [2:0]  rs_pos, en_pos, light_pos;
  logic [7:0]  cmd_mark, data_mark;
  lcd_out_t    due_bytes [$];
  int          n_fail;

  function new();
    wr = 0;
    rd = 0;
    step = INIT_STEP_CLEAR;
    q_empty = 1'b1;
    ovf_seen = 1'b0;
    sending = 1'b0;
    rdy = 1'b0;
    light_on = 1'b0;
    frame_busy = 1'b0;
    rs_pos = RS_POS_RST;
    en_pos = EN_POS_RST;
    light_pos = LIGHT_POS_RST;
    cmd_mark = CMD_MARK_RST;
    data_mark = DATA_MARK_RST;
    n_fail = 0;
  endfunction

  function int unsigned bump(int unsigned i);
    return (i + 1 >= QUEUE_DEPTH) ? 0 : i + 1;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] v);
    case (idx)
      CFG_RS_POS:    rs_pos = v[2:0];
      CFG_EN_POS:    en_pos = v[2:0];
      CFG_LIGHT_POS: light_pos = v[2:0];
      CFG_CMD_MARK:  cmd_mark = v;
      CFG_DATA_MARK: data_mark = v;
      default: ;
    endcase
  endfunction

  function void emit(int n);
    for (int k = 0; k < n; k++) due_bytes.push_back({frame[k], k == n - 1, 1'b0});
  endfunction

  function void boot_step();
    logic [7:0] hi, lo, en;
    if (step >= INIT_STEP_DONE) begin
      rdy = 1'b1;
      light_on = 1'b1;
      step = INIT_STEP_DONE;
      return;
    end
    if (step == INIT_STEP_CLEAR) begin
      q_empty = 1'b1;
      rd = 0;
      wr = 0;
      step = step + 1;
      return;
    end
    hi = BOOT_HI[step];
    lo = BOOT_LO[step];
    en = 8'h01 << en_pos;
    frame[0] = hi | en;
    frame[1] = hi;
    frame[2] = lo | en;
    frame[3] = lo;
    emit((lo != 8'h00) ? 4 : 2);
    step = step + 1;
  endfunction

  function void service();
    int unsigned nr;
    logic [7:0]  b, ctl, en;
    bit          is_data;
    if (!sending || frame_busy || q_empty) return;
    b = store[rd];
    is_data = 1'b1;
    if (b == cmd_mark || b == data_mark) begin
      nr = bump(rd);
      // marker with nothing behind it yet: wait
      if (nr == wr) return;
      is_data = (b != cmd_mark);
      rd = nr;
      b = store[nr];
    end
    en = 8'h01 << en_pos;
    ctl = 8'h00;
    if (is_data) ctl |= 8'h01 << rs_pos;
    if (light_on) ctl |= 8'h01 << light_pos;
    frame[1] = ctl | (b & HI_NIB_MASK);
    frame[0] = frame[1] | en;
    frame[3] = ctl | {b[3:0], 4'h0};
    frame[2] = frame[3] | en;
    frame_busy = 1'b1;
    emit(4);
  endfunction

  function void note_request(op_t op, logic [7:0] d, logic e);
    case (op)
      OP_PUSH: begin
        if (wr != rd || q_empty) begin
          q_empty = 1'b0;
          store[wr] = d;
          wr = bump(wr);
        end else begin
          ovf_seen = 1'b1;
          due_bytes.push_back({8'h00, 1'b0, 1'b1});
        end
      end
      OP_START: sending = 1'b1;
      OP_TICK: begin
        if (rdy) service();
        else boot_step();
      end
      OP_DONE: begin
        if (frame_busy) begin
          if (e) begin
            emit(4);
          end else begin
            frame_busy = 1'b0;
            rd = bump(rd);
            if (rd == wr) begin
              sending = 1'b0;
              q_empty = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  task report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    n_fail++;
  endtask

  task check_byte(lcd_out_t got);
    lcd_out_t want;
    if (due_bytes.size() == 0) begin
      report($sformatf("unexpected result byte=%02h last=%0b ovf=%0b",
                       got.xbyte, got.last, got.ovf));
      return;
    end
    want = due_bytes.pop_front();
    if (got.xbyte !== want.xbyte)
      report($sformatf("expander_byte %02h, expected %02h", got.xbyte, want.xbyte));
    if (got.last !== want.last)
      report($sformatf("last_of_frame %0b, expected %0b", got.last, want.last));
    if (got.ovf !== want.ovf)
      report($sformatf("overflow %0b, expected %0b", got.ovf, want.ovf));
  endtask
endclass

module char_lcd_i2c_expander_feeder_tb;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = '1;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_push, in_full;
  logic [1:0]           in_kind;
  logic [7:0]           in_data_byte;
  logic                 in_bus_error;
  logic                 out_empty, out_pop;
  logic [7:0]           out_expander_byte;
  logic                 out_last_of_frame, out_overflow;
  logic                 cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  frame_tracker sb = new();
  bit           calm = 1'b0;
  int unsigned  cycle_cnt = 0;

  char_lcd_i2c_expander_feeder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_kind           (in_kind),
    .in_data_byte      (in_data_byte),
    .in_bus_error      (in_bus_error),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_expander_byte (out_expander_byte),
    .out_last_of_frame (out_last_of_frame),
    .out_overflow      (out_overflow),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("char_lcd_i2c_expander_feeder_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      sb.check_byte({out_expander_byte, out_last_of_frame, out_overflow});
  end

  // mostly short gaps, now and then a long one; none during calm stretches
  function automatic int unsigned gap_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return sb.cmd_mark;
    if (r < 32) return sb.data_mark;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int unsigned g;
    out_pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      g = gap_len();
      if (g > 0) begin
        @(negedge clk);
        out_pop <= 1'b0;
        repeat (g - 1) @(negedge clk);
      end
      @(negedge clk);
      out_pop <= 1'b1;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  end

  task automatic send_req(op_t op, logic [7:0] d, logic e);
    int unsigned g;
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      in_push <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_push      <= 1'b1;
    in_kind      <= op;
    in_data_byte <= d;
    in_bus_error <= e;
    do @(posedge clk); while (in_full);
    sb.note_request(op, d, e);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // bit positions get random upper bits, which the block must ignore
  task automatic set_layout(logic [2:0] rs, logic [2:0] en, logic [2:0] lt,
                            logic [7:0] cmd, logic [7:0] dat);
    write_reg(CFG_RS_POS, {5'($urandom_range(0, 31)), rs});
    write_reg(CFG_EN_POS, {5'($urandom_range(0, 31)), en});
    write_reg(CFG_LIGHT_POS, {5'($urandom_range(0, 31)), lt});
    write_reg(CFG_CMD_MARK, cmd);
    write_reg(CFG_DATA_MARK, dat);
  endtask

  task automatic settle();
    @(negedge clk);
    in_push <= 1'b0;
    while (sb.due_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_item();
    int unsigned r;
    if ($urandom_range(0, 15) == 0) calm = !calm;
    if (sb.frame_busy && $urandom_range(0, 99) < 60) begin
      send_req(OP_DONE, 8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 40) send_req(OP_PUSH, pick_byte(), 1'($urandom_range(0, 1)));
      else if (r < 50) send_req(OP_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else if (r < 92) send_req(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else send_req(OP_DONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic fill_queue();
    while (sb.wr != sb.rd || sb.q_empty)
      send_req(OP_PUSH, pick_byte(), 1'($urandom_range(0, 1)));
    // queue full: these two are dropped
    repeat (2) send_req(OP_PUSH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic drain_queue();
    logic [7:0] b;
    while (!sb.q_empty) begin
      if (sb.frame_busy) begin
        send_req(OP_DONE, 8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
      end else if (!sb.sending) begin
        send_req(OP_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        send_req(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        if (!sb.frame_busy) begin
          // a marker sits at the tail; give it a plain byte to announce
          do b = 8'($urandom_range(0, 255)); while (b == sb.cmd_mark || b == sb.data_mark);
          send_req(OP_PUSH, b, 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_kind      = OP_PUSH;
    in_data_byte = 8'h00;
    in_bus_error = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_RS_POS;
    cfg_data     = 8'h00;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_req(OP_PUSH, 8'h5A, 1'b0);             // lost to the power-up clear
    repeat (11) send_req(OP_TICK, 8'h00, 1'b1); // clear, nine frames, ready
    send_req(OP_DONE, 8'hFF, 1'b1);             // nothing in flight
    send_req(OP_PUSH, sb.cmd_mark, 1'b0);
    send_req(OP_PUSH, 8'hFF, 1'b1);
    send_req(OP_TICK, 8'h00, 1'b0);             // not started yet
    send_req(OP_START, 8'h00, 1'b0);
    send_req(OP_TICK, 8'h00, 1'b0);             // command frame
    send_req(OP_TICK, 8'h00, 1'b0);             // frame in flight
    send_req(OP_DONE, 8'h00, 1'b1);             // bus error: resend
    send_req(OP_DONE, 8'h00, 1'b0);             // queue drained
    send_req(OP_PUSH, sb.data_mark, 1'b0);
    send_req(OP_PUSH, 8'h00, 1'b0);
    send_req(OP_PUSH, 8'hC3, 1'b0);
    send_req(OP_PUSH, sb.cmd_mark, 1'b0);
    send_req(OP_START, 8'h00, 1'b0);
    send_req(OP_TICK, 8'h00, 1'b0);
    send_req(OP_DONE, 8'h00, 1'b0);
    send_req(OP_TICK, 8'h00, 1'b0);             // plain byte
    send_req(OP_DONE, 8'h00, 1'b0);
    send_req(OP_TICK, 8'h00, 1'b0);             // marker at the tail waits
    send_req(OP_PUSH, 8'h81, 1'b0);
    send_req(OP_TICK, 8'h00, 1'b0);
    send_req(OP_DONE, 8'h00, 1'b0);
    send_req(OP_START, 8'h00, 1'b0);
    send_req(OP_TICK, 8'h00, 1'b0);             // empty queue

    repeat (6) random_item();
    settle();
    set_layout(3'd7, 3'd0, 3'd7, 8'h00, 8'hFF);
    repeat (6) random_item();
    settle();
    // equal markers, then overflow and a full drain
    set_layout(3'd3, 3'd5, 3'd1, 8'hA5, 8'hA5);
    fill_queue();
    drain_queue();
    settle();
    set_layout(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
    repeat (6) random_item();
    settle();
    set_layout(3'd0, 3'd0, 3'd0, 8'hFF, 8'h00);
    repeat (6) random_item();
    settle();

    if (sb.n_fail == 0)
      $display("char_lcd_i2c_expander_feeder_tb: PASS");
    else
      $display("char_lcd_i2c_expander_feeder_tb: FAIL");
    $finish;
  end

endmodule
